// ===== sv/ray_segment_nearest_hit_unit_assert.svh =====
// assertion macros for the ray segment nearest hit unit
// no dependencies; included by the top level only
`ifndef RAY_SEGMENT_NEAREST_HIT_UNIT_ASSERT_SVH
`define RAY_SEGMENT_NEAREST_HIT_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define RSNH_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rsnh assertion failed");
// next-cycle implication
`define RSNH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rsnh assertion failed");
`else
`define RSNH_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define RSNH_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== sv/rsnh_pkg.sv =====
// shared widths, command and status types of the nearest hit unit
// no dependencies
`default_nettype none
package rsnh_pkg;
	localparam int COORD_W   = 24;
	localparam int DELTA_W   = COORD_W + 1;
	localparam int MAG_W     = DELTA_W + 1;
	localparam int MOP_W     = MAG_W + 1;
	localparam int PROD_W    = 2 * MOP_W;
	localparam int SPLIT_W   = MAG_W;
	localparam int NUM_W     = 2 * PROD_W - SPLIT_W;
	localparam int QUO_W     = MAG_W;
	localparam int REM_W     = PROD_W + 1;
	localparam int DIST_W    = MAG_W + 1;
	localparam int CNT_W     = 5;

	// multiplier product indices
	localparam logic [3:0] P_DEN_A = 4'd0;
	localparam logic [3:0] P_DEN_B = 4'd1;
	localparam logic [3:0] P_NA_A  = 4'd2;
	localparam logic [3:0] P_NA_B  = 4'd3;
	localparam logic [3:0] P_NB_A  = 4'd4;
	localparam logic [3:0] P_NB_B  = 4'd5;
	localparam logic [3:0] P_X_LO  = 4'd6;
	localparam logic [3:0] P_X_HI  = 4'd7;
	localparam logic [3:0] P_Y_LO  = 4'd8;
	localparam logic [3:0] P_Y_HI  = 4'd9;
	localparam logic [3:0] P_LAST  = 4'd10;

	typedef struct packed {
		logic       capture;
		logic       load_first;
		logic       calc_delta;
		logic       mul_issue;
		logic [3:0] mul_sel;
		logic       acc_en;
		logic [3:0] acc_sel;
		logic       norm;
		logic       num_fin;
		logic       div_init;
		logic       div_step;
		logic       upd;
		logic       out_load;
	} rsnh_cmd_t;

	typedef struct packed {
		logic hit_ok;
		logic den_nz;
	} rsnh_stat_t;

	function automatic logic [MAG_W-1:0] abs_delta(input logic signed [DELTA_W-1:0] d);
		logic [MAG_W-1:0] e;
		e = MAG_W'(unsigned'(d));
		if (d[DELTA_W-1]) begin
			e = {1'b0, -d};
		end
		if (d[DELTA_W-1]) begin
			e = MAG_W'(0) - {1'b1, d};
		end
		return e;
	endfunction
endpackage
`default_nettype wire

// ===== sv/ray_segment_nearest_hit_unit.sv =====
// top level of the ray segment nearest hit unit
// depends on rsnh_pkg, rsnh_ctrl, rsnh_dp and the assertion macro header
//
//  channel | handshake           | payload
//  in      | in_valid / in_ready | first/last flags, ray origin and far point, segment ends
//  out     | out_valid/out_ready | end_x, end_y, hit_seen, ray_done
//
// a segment that misses goes from accept to result without the divider; a hit also
// runs the 26-step restoring divider for the hit point. the shared multiplier
// forms 10 products, one a cycle. the next transaction can be taken in the cycle
// after the result is loaded.
// one transaction is in work at a time; a finished result waits in the output
// register while the next transaction is taken in, and a stalled output holds
// the block only when a second result is ready. reset clears the ray end to (0,0).
`default_nettype none
module ray_segment_nearest_hit_unit import rsnh_pkg::*; (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic                      first_segment,
	input  wire logic                      last_segment,
	input  wire logic signed [COORD_W-1:0] ray_origin_x,
	input  wire logic signed [COORD_W-1:0] ray_origin_y,
	input  wire logic signed [COORD_W-1:0] ray_far_x,
	input  wire logic signed [COORD_W-1:0] ray_far_y,
	input  wire logic signed [COORD_W-1:0] seg_start_x,
	input  wire logic signed [COORD_W-1:0] seg_start_y,
	input  wire logic signed [COORD_W-1:0] seg_end_x,
	input  wire logic signed [COORD_W-1:0] seg_end_y,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic signed [COORD_W-1:0]      end_x,
	output logic signed [COORD_W-1:0]      end_y,
	output logic                           hit_seen,
	output logic                           ray_done
);
`include "ray_segment_nearest_hit_unit_assert.svh"

	rsnh_cmd_t  cmd;
	rsnh_stat_t stat;

	// sequencer
	rsnh_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.cmd       (cmd)
	);

	// arithmetic
	rsnh_dp u_dp (
		.clk           (clk),
		.cmd           (cmd),
		.arst_n        (arst_n),
		.first_segment (first_segment),
		.last_segment  (last_segment),
		.ray_origin_x  (ray_origin_x),
		.ray_origin_y  (ray_origin_y),
		.ray_far_x     (ray_far_x),
		.ray_far_y     (ray_far_y),
		.seg_start_x   (seg_start_x),
		.seg_start_y   (seg_start_y),
		.seg_end_x     (seg_end_x),
		.seg_end_y     (seg_end_y),
		.stat          (stat),
		.end_x         (end_x),
		.end_y         (end_y),
		.hit_seen      (hit_seen),
		.ray_done      (ray_done)
	);

	// checks
	`RSNH_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready)
	`RSNH_ASSERT_IMPLY(a_div_nonzero, clk, arst_n, cmd.div_step || cmd.div_init, stat.den_nz)
	`RSNH_ASSERT_IMPLY(a_capture_idle, clk, arst_n, cmd.capture, in_ready && in_valid)
endmodule
`default_nettype wire

// ===== sv/rsnh_dp.sv =====
// datapath: operand registers, shared multiplier, accumulators, twin dividers
// depends on rsnh_pkg
`default_nettype none
module rsnh_dp import rsnh_pkg::*; (
	input  wire logic                      clk,
	input  wire rsnh_cmd_t                 cmd,
	input  wire logic                      arst_n,
	input  wire logic                      first_segment,
	input  wire logic                      last_segment,
	input  wire logic signed [COORD_W-1:0] ray_origin_x,
	input  wire logic signed [COORD_W-1:0] ray_origin_y,
	input  wire logic signed [COORD_W-1:0] ray_far_x,
	input  wire logic signed [COORD_W-1:0] ray_far_y,
	input  wire logic signed [COORD_W-1:0] seg_start_x,
	input  wire logic signed [COORD_W-1:0] seg_start_y,
	input  wire logic signed [COORD_W-1:0] seg_end_x,
	input  wire logic signed [COORD_W-1:0] seg_end_y,
	output rsnh_stat_t                     stat,
	output logic signed [COORD_W-1:0]      end_x,
	output logic signed [COORD_W-1:0]      end_y,
	output logic                           hit_seen,
	output logic                           ray_done
);
	logic                      first_q, last_q;
	logic signed [COORD_W-1:0] ox_q, oy_q, fx_q, fy_q, ax_q, ay_q, bx_q, by_q;
	logic signed [COORD_W-1:0] run_x_q, run_y_q;
	logic                      any_hit_q;
	logic signed [DELTA_W-1:0] dx_q, dy_q, ex_q, ey_q, wx_q, wy_q;
	logic signed [MOP_W-1:0]   mop_a, mop_b;
	logic signed [PROD_W-1:0]  prod_q;
	logic signed [PROD_W-1:0]  den_q, na_q, nb_q;
	logic [NUM_W-1:0]          numx_q, numy_q;
	logic [REM_W-1:0]          remx_q, remy_q, dv_q;
	logic [SPLIT_W-1:0]        nlx_q, nly_q;
	logic [QUO_W-1:0]          qx_q, qy_q;
	logic [REM_W-1:0]          tx, ty;
	logic [MAG_W-1:0]          mdx, mdy;
	logic [DIST_W-1:0]         dcur, dhit;
	logic signed [QUO_W:0]     stepx, stepy;
	logic signed [QUO_W+1:0]   hx, hy;

	assign mdx = abs_delta(dx_q);
	assign mdy = abs_delta(dy_q);

	// input capture
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			first_q <= first_segment;
			last_q  <= last_segment;
			ox_q <= ray_origin_x;
			oy_q <= ray_origin_y;
			fx_q <= ray_far_x;
			fy_q <= ray_far_y;
			ax_q <= seg_start_x;
			ay_q <= seg_start_y;
			bx_q <= seg_end_x;
			by_q <= seg_end_y;
		end
	end

	// differences of the current ray and segment
	always_ff @(posedge clk) begin
		if (cmd.calc_delta) begin
			dx_q <= DELTA_W'(run_x_q) - DELTA_W'(ox_q);
			dy_q <= DELTA_W'(run_y_q) - DELTA_W'(oy_q);
			ex_q <= DELTA_W'(bx_q) - DELTA_W'(ax_q);
			ey_q <= DELTA_W'(by_q) - DELTA_W'(ay_q);
			wx_q <= DELTA_W'(ox_q) - DELTA_W'(ax_q);
			wy_q <= DELTA_W'(oy_q) - DELTA_W'(ay_q);
		end
	end

	// multiplier operand select
	always_comb begin
		mop_a = '0;
		mop_b = '0;
		case (cmd.mul_sel)
			P_DEN_A: begin mop_a = MOP_W'(ey_q); mop_b = MOP_W'(dx_q); end
			P_DEN_B: begin mop_a = MOP_W'(ex_q); mop_b = MOP_W'(dy_q); end
			P_NA_A:  begin mop_a = MOP_W'(ex_q); mop_b = MOP_W'(wy_q); end
			P_NA_B:  begin mop_a = MOP_W'(ey_q); mop_b = MOP_W'(wx_q); end
			P_NB_A:  begin mop_a = MOP_W'(dx_q); mop_b = MOP_W'(wy_q); end
			P_NB_B:  begin mop_a = MOP_W'(dy_q); mop_b = MOP_W'(wx_q); end
			P_X_LO:  begin mop_a = {1'b0, na_q[SPLIT_W-1:0]}; mop_b = {1'b0, mdx}; end
			P_X_HI:  begin mop_a = {1'b0, na_q[2*SPLIT_W-1:SPLIT_W]}; mop_b = {1'b0, mdx}; end
			P_Y_LO:  begin mop_a = {1'b0, na_q[SPLIT_W-1:0]}; mop_b = {1'b0, mdy}; end
			P_Y_HI:  begin mop_a = {1'b0, na_q[2*SPLIT_W-1:SPLIT_W]}; mop_b = {1'b0, mdy}; end
			default: begin mop_a = '0; mop_b = '0; end
		endcase
	end

	// shared multiplier, registered product
	always_ff @(posedge clk) begin
		if (cmd.mul_issue) begin
			prod_q <= mop_a * mop_b;
		end
	end

	// accumulate cross products and hit-point numerators, sign normalize
	always_ff @(posedge clk) begin
		if (cmd.acc_en) begin
			case (cmd.acc_sel)
				P_DEN_A: den_q <= prod_q;
				P_DEN_B: den_q <= den_q - prod_q;
				P_NA_A:  na_q  <= prod_q;
				P_NA_B:  na_q  <= na_q - prod_q;
				P_NB_A:  nb_q  <= prod_q;
				P_NB_B:  nb_q  <= nb_q - prod_q;
				P_X_LO:  numx_q <= NUM_W'(unsigned'(prod_q));
				P_X_HI:  numx_q <= numx_q +
					{(NUM_W-SPLIT_W)'(unsigned'(prod_q)), SPLIT_W'(0)};
				P_Y_LO:  numy_q <= NUM_W'(unsigned'(prod_q));
				P_Y_HI:  numy_q <= numy_q +
					{(NUM_W-SPLIT_W)'(unsigned'(prod_q)), SPLIT_W'(0)};
				default: ;
			endcase
		end else if (cmd.norm && den_q[PROD_W-1]) begin
			den_q <= -den_q;
			na_q  <= -na_q;
			nb_q  <= -nb_q;
		end else if (cmd.num_fin) begin
			numx_q <= {numx_q[NUM_W-2:0], 1'b0} + NUM_W'(unsigned'(den_q));
			numy_q <= {numy_q[NUM_W-2:0], 1'b0} + NUM_W'(unsigned'(den_q));
		end
	end

	assign stat.den_nz = (den_q != '0);
	assign stat.hit_ok = (den_q != '0) && !na_q[PROD_W-1] && !nb_q[PROD_W-1] &&
		(na_q <= den_q) && (nb_q <= den_q);

	// restoring dividers for both coordinates, one quotient bit a cycle
	assign tx = {remx_q[REM_W-2:0], nlx_q[SPLIT_W-1]};
	assign ty = {remy_q[REM_W-2:0], nly_q[SPLIT_W-1]};

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			remx_q <= REM_W'(numx_q[NUM_W-1:SPLIT_W]);
			remy_q <= REM_W'(numy_q[NUM_W-1:SPLIT_W]);
			nlx_q  <= numx_q[SPLIT_W-1:0];
			nly_q  <= numy_q[SPLIT_W-1:0];
			dv_q   <= REM_W'({unsigned'(den_q), 1'b0});
			qx_q   <= '0;
			qy_q   <= '0;
		end else if (cmd.div_step) begin
			nlx_q <= {nlx_q[SPLIT_W-2:0], 1'b0};
			nly_q <= {nly_q[SPLIT_W-2:0], 1'b0};
			if (tx >= dv_q) begin
				remx_q <= tx - dv_q;
				qx_q   <= {qx_q[QUO_W-2:0], 1'b1};
			end else begin
				remx_q <= tx;
				qx_q   <= {qx_q[QUO_W-2:0], 1'b0};
			end
			if (ty >= dv_q) begin
				remy_q <= ty - dv_q;
				qy_q   <= {qy_q[QUO_W-2:0], 1'b1};
			end else begin
				remy_q <= ty;
				qy_q   <= {qy_q[QUO_W-2:0], 1'b0};
			end
		end
	end

	// hit point and manhattan distances
	assign stepx = dx_q[DELTA_W-1] ? -signed'({1'b0, qx_q}) : signed'({1'b0, qx_q});
	assign stepy = dy_q[DELTA_W-1] ? -signed'({1'b0, qy_q}) : signed'({1'b0, qy_q});
	assign hx    = (QUO_W+2)'(ox_q) + (QUO_W+2)'(stepx);
	assign hy    = (QUO_W+2)'(oy_q) + (QUO_W+2)'(stepy);
	assign dcur  = DIST_W'(mdx) + DIST_W'(mdy);
	assign dhit  = DIST_W'(qx_q) + DIST_W'(qy_q);

	// running ray end and hit flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_x_q   <= '0;
			run_y_q   <= '0;
			any_hit_q <= 1'b0;
		end else if (cmd.load_first && first_q) begin
			run_x_q   <= fx_q;
			run_y_q   <= fy_q;
			any_hit_q <= 1'b0;
		end else if (cmd.upd) begin
			any_hit_q <= 1'b1;
			if (dcur >= dhit) begin
				run_x_q <= hx[COORD_W-1:0];
				run_y_q <= hy[COORD_W-1:0];
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			end_x    <= run_x_q;
			end_y    <= run_y_q;
			hit_seen <= any_hit_q;
			ray_done <= last_q;
		end
	end
endmodule
`default_nettype wire

// ===== sv/rsnh_ctrl.sv =====
// controller: sequences multiply, normalize, test, divide and update steps
// depends on rsnh_pkg
`default_nettype none
module rsnh_ctrl import rsnh_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire logic       out_ready,
	input  wire rsnh_stat_t stat,
	output logic            in_ready,
	output logic            out_valid,
	output rsnh_cmd_t       cmd
);
	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_LOAD  = 4'd1;
	localparam logic [3:0] ST_DELTA = 4'd2;
	localparam logic [3:0] ST_MUL   = 4'd3;
	localparam logic [3:0] ST_NORM  = 4'd4;
	localparam logic [3:0] ST_TEST  = 4'd5;
	localparam logic [3:0] ST_LMUL  = 4'd6;
	localparam logic [3:0] ST_NUMF  = 4'd7;
	localparam logic [3:0] ST_DIVI  = 4'd8;
	localparam logic [3:0] ST_DIV   = 4'd9;
	localparam logic [3:0] ST_UPD   = 4'd10;
	localparam logic [3:0] ST_DONE  = 4'd11;

	// step after the last cross product
	localparam logic [3:0] P_NORM_END = P_NB_B + 4'd1;

	logic [3:0]       state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             out_valid_q;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.capture = in_valid;
				if (in_valid) begin
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				cmd.load_first = 1'b1;
				state_d = ST_DELTA;
			end
			ST_DELTA: begin
				cmd.calc_delta = 1'b1;
				cnt_d   = '0;
				state_d = ST_MUL;
			end
			ST_MUL, ST_LMUL: begin
				cmd.mul_sel   = cnt_q[3:0];
				cmd.acc_sel   = cnt_q[3:0] - 4'd1;
				cmd.mul_issue = (state_q == ST_MUL) ? (cnt_q[3:0] != P_NORM_END)
					: (cnt_q[3:0] != P_LAST);
				cmd.acc_en    = (state_q == ST_MUL) ? (cnt_q[3:0] != P_DEN_A)
					: (cnt_q[3:0] != P_X_LO);
				cnt_d = cnt_q + CNT_W'(1);
				if (state_q == ST_MUL && cnt_q[3:0] == P_NORM_END) begin
					state_d = ST_NORM;
				end else if (state_q == ST_LMUL && cnt_q[3:0] == P_LAST) begin
					state_d = ST_NUMF;
				end
			end
			ST_NORM: begin
				cmd.norm = 1'b1;
				state_d = ST_TEST;
			end
			ST_TEST: begin
				cnt_d   = CNT_W'(P_X_LO);
				state_d = stat.hit_ok ? ST_LMUL : ST_DONE;
			end
			ST_NUMF: begin
				cmd.num_fin = 1'b1;
				state_d = ST_DIVI;
			end
			ST_DIVI: begin
				cmd.div_init = 1'b1;
				cnt_d   = '0;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				cnt_d = cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(QUO_W - 1)) begin
					state_d = ST_UPD;
				end
			end
			ST_UPD: begin
				cmd.upd = 1'b1;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state, step counter and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end
endmodule
`default_nettype wire

// ===== tb/sv/ray_segment_nearest_hit_checker.sv =====
// transaction checker for the ray segment nearest hit unit: predicts the clipped ray end
// depends on rsnh_pkg for the coordinate width
`timescale 1ns / 1ps
module ray_segment_nearest_hit_checker import rsnh_pkg::*; (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	input  wire logic                      in_ready,
	input  wire logic                      first_segment,
	input  wire logic                      last_segment,
	input  wire logic signed [COORD_W-1:0] ray_origin_x,
	input  wire logic signed [COORD_W-1:0] ray_origin_y,
	input  wire logic signed [COORD_W-1:0] ray_far_x,
	input  wire logic signed [COORD_W-1:0] ray_far_y,
	input  wire logic signed [COORD_W-1:0] seg_start_x,
	input  wire logic signed [COORD_W-1:0] seg_start_y,
	input  wire logic signed [COORD_W-1:0] seg_end_x,
	input  wire logic signed [COORD_W-1:0] seg_end_y,
	input  wire logic                      out_valid,
	input  wire logic                      out_ready,
	input  wire logic signed [COORD_W-1:0] end_x,
	input  wire logic signed [COORD_W-1:0] end_y,
	input  wire logic                      hit_seen,
	input  wire logic                      ray_done,
	output int                             fail_count,
	output int                             pending
);
	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic               hit;
		logic               done;
	} ray_end_t;

	ray_end_t end_queue[$];
	longint   cur_x, cur_y;
	bit       cur_hit;

	// hit point coordinate: origin + ua*delta, rounded half away from zero
	function automatic longint hit_coord(longint org, longint delta, longint ua_num,
			longint ua_den);
		logic [127:0] num, quo, mag_d;
		mag_d = (delta < 0) ? 128'(-delta) : 128'(delta);
		num = 2 * 128'(ua_num) * mag_d + 128'(ua_den);
		quo = num / (2 * 128'(ua_den));
		return (delta < 0) ? org - longint'(quo) : org + longint'(quo);
	endfunction

	function automatic longint abs_l(longint v);
		return (v < 0) ? -v : v;
	endfunction

	// advance the running ray end by one segment test
	task automatic clip_to_segment();
		longint ox, oy, ax, ay, bx, by, dx, dy, ex, ey, wx, wy;
		longint den, na, nb, hx, hy;
		ray_end_t r;
		ox = ray_origin_x; oy = ray_origin_y;
		ax = seg_start_x;  ay = seg_start_y;
		bx = seg_end_x;    by = seg_end_y;
		if (first_segment) begin
			cur_x = ray_far_x;
			cur_y = ray_far_y;
			cur_hit = 0;
		end
		dx = cur_x - ox; dy = cur_y - oy;
		ex = bx - ax;    ey = by - ay;
		wx = ox - ax;    wy = oy - ay;
		den = ey * dx - ex * dy;
		na = ex * wy - ey * wx;
		nb = dx * wy - dy * wx;
		// parallel or degenerate pairs never hit
		if (den != 0) begin
			if (den < 0) begin
				den = -den; na = -na; nb = -nb;
			end
			if (na >= 0 && nb >= 0 && na <= den && nb <= den) begin
				hx = hit_coord(ox, dx, na, den);
				hy = hit_coord(oy, dy, na, den);
				cur_hit = 1;
				// ties go to the hit
				if (abs_l(ox - cur_x) + abs_l(oy - cur_y) >= abs_l(ox - hx) + abs_l(oy - hy)) begin
					cur_x = hx;
					cur_y = hy;
				end
			end
		end
		r.x = cur_x[COORD_W-1:0];
		r.y = cur_y[COORD_W-1:0];
		r.hit = cur_hit;
		r.done = last_segment;
		end_queue.push_back(r);
	endtask

	assign pending = end_queue.size();

	always @(posedge clk or negedge arst_n) begin
		ray_end_t e;
		if (!arst_n) begin
			cur_x = 0; cur_y = 0; cur_hit = 0;
			fail_count = 0;
			end_queue.delete();
		end else begin
			// compare before predicting so a same-edge input never pairs with this result
			if (out_valid && out_ready) begin
				if (end_queue.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result x=%h y=%h hit=%b done=%b",
							end_x, end_y, hit_seen, ray_done);
				end else begin
					e = end_queue.pop_front();
					if (e.x !== end_x || e.y !== end_y || e.hit !== hit_seen
							|| e.done !== ray_done) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch: exp x=%h y=%h hit=%b done=%b, got x=%h y=%h hit=%b done=%b",
								e.x, e.y, e.hit, e.done, end_x, end_y, hit_seen, ray_done);
					end
				end
			end
			if (in_valid && in_ready)
				clip_to_segment();
		end
	end
endmodule

// ===== tb/sv/ray_segment_nearest_hit_unit_tb.sv =====
// top of the ray segment nearest hit testbench: clock, reset, stimulus and verdict
// depends on rsnh_pkg, ray_segment_nearest_hit_unit and ray_segment_nearest_hit_checker
`timescale 1ns / 1ps
module ray_segment_nearest_hit_unit_tb;
	import rsnh_pkg::*;

	localparam int RAND_ITEMS = 1830;

	logic clk, arst_n;
	logic in_valid, in_ready, out_valid, out_ready;
	logic first_segment, last_segment;
	logic signed [COORD_W-1:0] ray_origin_x, ray_origin_y, ray_far_x, ray_far_y;
	logic signed [COORD_W-1:0] seg_start_x, seg_start_y, seg_end_x, seg_end_y;
	logic signed [COORD_W-1:0] end_x, end_y;
	logic hit_seen, ray_done;
	int   fail_count, pending;
	int   sent;
	bit   burst_mode, rx_hold;
	int   rx_wait;

	ray_segment_nearest_hit_unit DUT (.*);
	ray_segment_nearest_hit_checker checker_i (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// a coordinate: full range, extremes or a modest value
	function automatic logic signed [COORD_W-1:0] pick_coord();
		case ($urandom_range(0, 9))
			0, 1:    return COORD_W'($urandom);
			2:       return $urandom_range(0, 1) ? {1'b0, {(COORD_W-1){1'b1}}}
						: {1'b1, {(COORD_W-1){1'b0}}};
			default: return COORD_W'($signed($urandom_range(0, 8000)) - 4000);
		endcase
	endfunction

	// one input transaction, after a random gap
	task automatic send_seg(input logic f, input logic l,
			input logic signed [COORD_W-1:0] ox, oy, fx, fy, sx, sy, ex, ey);
		int gap;
		gap = burst_mode ? 0 : $urandom_range(0, 19);
		repeat (gap) @(negedge clk);
		in_valid = 1;
		first_segment = f; last_segment = l;
		ray_origin_x = ox; ray_origin_y = oy; ray_far_x = fx; ray_far_y = fy;
		seg_start_x = sx; seg_start_y = sy; seg_end_x = ex; seg_end_y = ey;
		// ready is stable at the falling edge; accept happens at the next rising edge
		while (!in_ready) @(negedge clk);
		@(negedge clk);
		in_valid = 0;
		sent++;
	endtask

	// receiver idling, with a hold-off forced from its own process
	always @(negedge clk) begin
		if (!arst_n || rx_hold) begin
			out_ready = 0;
		end else if (rx_wait > 0) begin
			out_ready = 0;
			rx_wait--;
		end else begin
			out_ready = 1;
		end
	end
	always @(posedge clk) begin
		if (out_valid && out_ready)
			rx_wait = burst_mode ? 0 : $urandom_range(0, 19);
	end

	initial begin
		rx_hold = 0;
		wait (arst_n);
		repeat (3000) @(posedge clk);
		rx_hold = 1;
		repeat (600) @(posedge clk);
		rx_hold = 0;
	end

	initial begin
		#10_000_000;
		$display("ray_segment_nearest_hit_unit test failed");
		$finish;
	end

	initial begin
		logic signed [COORD_W-1:0] ox, oy, fx, fy, px, py, ax, ay;
		logic signed [COORD_W-1:0] maxc, minc;
		int nseg, r;
		maxc = {1'b0, {(COORD_W-1){1'b1}}};
		minc = {1'b1, {(COORD_W-1){1'b0}}};
		arst_n = 0; in_valid = 0; out_ready = 0; rx_wait = 0; burst_mode = 0; sent = 0;
		{first_segment, last_segment} = '0;
		{ray_origin_x, ray_origin_y, ray_far_x, ray_far_y} = '0;
		{seg_start_x, seg_start_y, seg_end_x, seg_end_y} = '0;
		repeat (8) @(negedge clk);
		arst_n = 1;

		// no new ray after reset: continues from (0,0), zero-length ray
		send_seg(0, 0, 0, 0, 100, 100, -10, 5, 10, -5);
		// plain crossing, then a farther one and a nearer one
		send_seg(1, 0, 0, 0, 1000, 0, 500, -100, 500, 100);
		send_seg(0, 0, 0, 0, 1000, 0, 800, -100, 800, 100);
		send_seg(0, 1, 0, 0, 1000, 0, 200, -100, 200, 100);
		// parallel and collinear pairs
		send_seg(1, 0, 0, 0, 1000, 0, 0, 5, 1000, 5);
		send_seg(0, 1, 0, 0, 1000, 0, -50, 0, 2000, 0);
		// tie: crossing exactly at the ray end, and segment touching its own end
		send_seg(1, 0, 0, 0, 100, 100, 100, 0, 100, 200);
		send_seg(0, 1, 0, 0, 100, 100, 0, 50, 50, 50);
		// rounding with halves away from zero, both directions
		send_seg(1, 0, 0, 0, 3, 1, 1, -1, 1, 2);
		send_seg(0, 1, 0, 0, -3, -1, -1, 1, -1, -2);
		// extremes of the coordinate range
		send_seg(1, 0, minc, minc, maxc, maxc, minc, maxc, maxc, minc);
		send_seg(0, 0, maxc, minc, minc, maxc, minc, minc, maxc, maxc);
		send_seg(0, 1, maxc, maxc, minc, minc, maxc, maxc, maxc, maxc);
		send_seg(1, 1, minc, maxc, maxc, minc, 0, 0, minc, minc);
		send_seg(1, 1, 0, 0, 0, 0, minc, 0, maxc, 0);

		// random rays: mostly crossing segments around a point on the ray, some noise
		while (sent < RAND_ITEMS + 15) begin
			if ($urandom_range(0, 99) < 3)
				burst_mode = !burst_mode;
			ox = pick_coord(); oy = pick_coord();
			fx = pick_coord(); fy = pick_coord();
			nseg = $urandom_range(1, 6);
			for (int i = 0; i < nseg; i++) begin
				r = $urandom_range(0, 16);
				px = COORD_W'(ox + (($signed(fx) - $signed(ox)) / 16) * r);
				py = COORD_W'(oy + (($signed(fy) - $signed(oy)) / 16) * r);
				ax = COORD_W'($signed($urandom_range(0, 2000)) - 1000);
				ay = COORD_W'($signed($urandom_range(0, 2000)) - 1000);
				if ($urandom_range(0, 3) == 0)
					send_seg(i == 0, i == nseg - 1, ox, oy, fx, fy,
						pick_coord(), pick_coord(), pick_coord(), pick_coord());
				else
					send_seg(i == 0, i == nseg - 1, ox, oy, fx, fy,
						px + ax, py + ay, px - ax, py - ay);
			end
		end
		burst_mode = 0;

		wait (pending == 0);
		repeat (100) @(posedge clk);
		if (fail_count == 0)
			$display("ray_segment_nearest_hit_unit test passed");
		else
			$display("ray_segment_nearest_hit_unit test failed");
		$finish;
	end
endmodule
